@@ rtl/core/u8sd_pkg.sv @@
// ----------------------------------------------------------------------------
// u8sd_pkg
// shared types and constants of the streaming utf-8 decoder
// ----------------------------------------------------------------------------
`default_nettype none

package u8sd_pkg;

  localparam int DATA_W      = 8;   // input byte
  localparam int CP_W        = 21;  // code point
  localparam int CNT_OUT_W   = 16;  // char_count port
  localparam int PAYLOAD_W   = 7;   // widest lead payload (ascii)
  localparam int CONT_BITS   = 6;   // bits carried by a continuation byte
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // byte masks and lead patterns
  localparam logic [DATA_W-1:0] ASCII_TOP  = 8'h80;
  localparam logic [DATA_W-1:0] CLS2_MASK  = 8'hE0;
  localparam logic [DATA_W-1:0] CLS2_CODE  = 8'hC0;
  localparam logic [DATA_W-1:0] CLS3_MASK  = 8'hF0;
  localparam logic [DATA_W-1:0] CLS3_CODE  = 8'hE0;
  localparam logic [DATA_W-1:0] CLS4_MASK  = 8'hF8;
  localparam logic [DATA_W-1:0] CLS4_CODE  = 8'hF0;
  localparam logic [DATA_W-1:0] CONT_MASK  = 8'hC0;
  localparam logic [DATA_W-1:0] CONT_CODE  = 8'h80;
  localparam logic [DATA_W-1:0] PAY1_MASK  = 8'h7F;
  localparam logic [DATA_W-1:0] PAY2_MASK  = 8'h1F;
  localparam logic [DATA_W-1:0] PAY3_MASK  = 8'h0F;
  localparam logic [DATA_W-1:0] PAY4_MASK  = 8'h07;
  localparam logic [DATA_W-1:0] PAYC_MASK  = 8'h3F;

  typedef enum logic [2:0] {
    CLS_TERM,
    CLS_ASCII,
    CLS_CONT,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_BAD
  } byte_class_t;

  typedef struct packed {
    byte_class_t          cls;
    logic [PAYLOAD_W-1:0] payload;  // ascii keeps 7 bits, all others the low 6
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

@@ rtl/core/u8sd_front.sv @@
// ----------------------------------------------------------------------------
// u8sd_front
// accepts input beats, classifies each byte and masks its payload
// ----------------------------------------------------------------------------
`default_nettype none

module u8sd_front (
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic [u8sd_pkg::DATA_W-1:0]   in_data_byte,
  output logic                               in_stall,
  input  wire u8sd_pkg::q_status_t           q_status,
  output logic                               push,
  output u8sd_pkg::q_entry_t                 push_entry
);

  logic [u8sd_pkg::DATA_W-1:0] masked;

  always_comb begin
    masked           = '0;
    push_entry.cls   = u8sd_pkg::CLS_BAD;
    if (in_data_byte == '0) begin
      push_entry.cls = u8sd_pkg::CLS_TERM;
    end else if ((in_data_byte & u8sd_pkg::ASCII_TOP) == '0) begin
      push_entry.cls = u8sd_pkg::CLS_ASCII;
      masked         = in_data_byte & u8sd_pkg::PAY1_MASK;
    end else if ((in_data_byte & u8sd_pkg::CONT_MASK) == u8sd_pkg::CONT_CODE) begin
      push_entry.cls = u8sd_pkg::CLS_CONT;
      masked         = in_data_byte & u8sd_pkg::PAYC_MASK;
    end else if ((in_data_byte & u8sd_pkg::CLS2_MASK) == u8sd_pkg::CLS2_CODE) begin
      // lead payloads are narrowed in the back end; the six low bits still
      // serve when the byte lands inside an open sequence
      push_entry.cls = u8sd_pkg::CLS_LEAD2;
      masked         = in_data_byte & u8sd_pkg::PAYC_MASK;
    end else if ((in_data_byte & u8sd_pkg::CLS3_MASK) == u8sd_pkg::CLS3_CODE) begin
      push_entry.cls = u8sd_pkg::CLS_LEAD3;
      masked         = in_data_byte & u8sd_pkg::PAYC_MASK;
    end else if ((in_data_byte & u8sd_pkg::CLS4_MASK) == u8sd_pkg::CLS4_CODE) begin
      push_entry.cls = u8sd_pkg::CLS_LEAD4;
      masked         = in_data_byte & u8sd_pkg::PAYC_MASK;
    end else begin
      // 11111xxx; continuation bits still kept for a byte inside a sequence
      push_entry.cls = u8sd_pkg::CLS_BAD;
      masked         = in_data_byte & u8sd_pkg::PAYC_MASK;
    end
    push_entry.payload = masked[u8sd_pkg::PAYLOAD_W-1:0];
  end

  // nothing is taken while reset is held
  assign in_stall = q_status.full || !rst_n;
  assign push     = in_valid && !in_stall;

endmodule

`default_nettype wire

@@ rtl/core/u8sd_queue.sv @@
// ----------------------------------------------------------------------------
// u8sd_queue
// short fifo of classified bytes between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module u8sd_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire u8sd_pkg::q_entry_t   push_entry,
  input  wire logic                 pop,
  output u8sd_pkg::q_entry_t        head_entry,
  output u8sd_pkg::q_status_t       q_status
);

  u8sd_pkg::q_entry_t                 mem_r [u8sd_pkg::QUEUE_DEPTH];
  logic [u8sd_pkg::QPTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [u8sd_pkg::QPTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [u8sd_pkg::QCNT_W-1:0]        cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head_entry     = mem_r[rd_ptr_r];
  assign q_status.full  = (cnt_r == u8sd_pkg::QCNT_W'(u8sd_pkg::QUEUE_DEPTH));
  assign q_status.empty = (cnt_r == '0);

  // fill level stays within depth, pointer distance agrees with it, and no pop from an empty queue
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= u8sd_pkg::QCNT_W'(u8sd_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");
  assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == cnt_r[u8sd_pkg::QPTR_W-1:0])
    else $error("queue pointers disagree with count");
  assert property (@(posedge clk) disable iff (!rst_n)
    q_status.empty |-> !pop)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

@@ rtl/core/u8sd_back.sv @@
// ----------------------------------------------------------------------------
// u8sd_back
// sequence state, character count and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module u8sd_back #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire u8sd_pkg::q_entry_t              head_entry,
  input  wire u8sd_pkg::q_status_t             q_status,
  output logic                                 pop,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [u8sd_pkg::CP_W-1:0]            out_code_point,
  output logic                                 out_char_valid,
  output logic                                 out_is_last,
  output logic [u8sd_pkg::CNT_OUT_W-1:0]       out_char_count,
  output logic                                 out_bad_lead
);

  localparam int CW = u8sd_pkg::CP_W;
  localparam int CB = u8sd_pkg::CONT_BITS;

  logic [1:0]            pending_r, pending_nxt;
  logic [CW-1:0]         partial_r, partial_nxt;
  logic [COUNT_BITS-1:0] chars_r, chars_nxt, chars_inc;
  logic                  err_r, err_nxt;

  logic                  emit;
  logic [CW-1:0]         res_cp;
  logic                  res_valid, res_last, res_bad;
  logic [COUNT_BITS-1:0] res_cnt;
  logic [CW-1:0]         cont_val;

  logic                  out_valid_r, out_valid_nxt;
  logic [CW-1:0]         cp_r;
  logic                  char_valid_r, is_last_r, bad_r;
  logic [u8sd_pkg::CNT_OUT_W-1:0] cnt_r;

  assign pop       = !q_status.empty && (!out_valid_r || !out_stall);
  assign chars_inc = (chars_r == {COUNT_BITS{1'b1}}) ? chars_r : chars_r + 1'b1;
  assign cont_val  = {partial_r[CW-CB-1:0], head_entry.payload[CB-1:0]};

  always_comb begin
    pending_nxt = pending_r;
    partial_nxt = partial_r;
    chars_nxt   = chars_r;
    err_nxt     = err_r;
    emit        = 1'b0;
    res_cp      = '0;
    res_valid   = 1'b0;
    res_last    = 1'b0;
    res_bad     = 1'b0;
    res_cnt     = '0;
    if (pop) begin
      if (head_entry.cls == u8sd_pkg::CLS_TERM) begin
        // close the string, flushing a cut-short sequence with zero fill
        emit     = 1'b1;
        res_last = 1'b1;
        res_bad  = err_r;
        if (pending_r != 2'd0 && !err_r) begin
          res_valid = 1'b1;
          case (pending_r)
            2'd1:    res_cp = {partial_r[CW-CB-1:0], {CB{1'b0}}};
            2'd2:    res_cp = {partial_r[CW-2*CB-1:0], {(2*CB){1'b0}}};
            2'd3:    res_cp = {partial_r[CW-3*CB-1:0], {(3*CB){1'b0}}};
            default: res_cp = '0;
          endcase
          res_cnt = chars_inc;
        end else begin
          res_cnt = err_r ? '0 : chars_r;
        end
        pending_nxt = '0;
        partial_nxt = '0;
        chars_nxt   = '0;
        err_nxt     = 1'b0;
      end else if (!err_r) begin
        if (pending_r != 2'd0) begin
          // any nonzero byte inside a sequence counts as a continuation
          pending_nxt = pending_r - 2'd1;
          if (pending_r == 2'd1) begin
            emit        = 1'b1;
            res_valid   = 1'b1;
            res_cp      = cont_val;
            chars_nxt   = chars_inc;
            partial_nxt = '0;
          end else begin
            partial_nxt = cont_val;
          end
        end else begin
          unique case (head_entry.cls) inside
            u8sd_pkg::CLS_ASCII: begin
              emit      = 1'b1;
              res_valid = 1'b1;
              res_cp    = CW'(head_entry.payload);
              chars_nxt = chars_inc;
            end
            u8sd_pkg::CLS_LEAD2: begin
              partial_nxt = CW'({1'b0, head_entry.payload} & u8sd_pkg::PAY2_MASK);
              pending_nxt = 2'd1;
            end
            u8sd_pkg::CLS_LEAD3: begin
              partial_nxt = CW'({1'b0, head_entry.payload} & u8sd_pkg::PAY3_MASK);
              pending_nxt = 2'd2;
            end
            u8sd_pkg::CLS_LEAD4: begin
              partial_nxt = CW'({1'b0, head_entry.payload} & u8sd_pkg::PAY4_MASK);
              pending_nxt = 2'd3;
            end
            u8sd_pkg::CLS_CONT, u8sd_pkg::CLS_BAD: begin
              err_nxt = 1'b1;
            end
            default: begin
              err_nxt = err_r;
            end
          endcase
        end
      end
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= '0;
      partial_r   <= '0;
      chars_r     <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pending_r   <= pending_nxt;
      partial_r   <= partial_nxt;
      chars_r     <= chars_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      cp_r         <= res_cp;
      char_valid_r <= res_valid;
      is_last_r    <= res_last;
      bad_r        <= res_bad;
      cnt_r        <= u8sd_pkg::CNT_OUT_W'(res_cnt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = cp_r;
  assign out_char_valid = char_valid_r;
  assign out_is_last    = is_last_r;
  assign out_bad_lead   = bad_r;
  assign out_char_count = cnt_r;

  // every beat carries a character or closes the string
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (char_valid_r || is_last_r))
    else $error("result beat with neither character nor terminator");
  // terminator leaves a clean state for the next string
  assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head_entry.cls == u8sd_pkg::CLS_TERM)
      |=> (pending_r == 2'd0 && !err_r && chars_r == '0))
    else $error("state not cleared after terminator");
  // no open sequence once the error is sticky
  assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> (pending_r == 2'd0))
    else $error("sequence open while error set");

endmodule

`default_nettype wire

@@ rtl/core/utf8_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// streaming utf-8 decoder for zero-terminated strings
// ----------------------------------------------------------------------------
// input channel: one string byte per beat on in_data_byte; a zero byte ends
//   the string. in_stall rises when the internal byte queue is full and is
//   held high while rst_n is low.
// output channel: one beat per completed character (out_char_valid set) and
//   one closing beat per string (out_is_last set) that carries out_char_count
//   and out_bad_lead. char_count is zero when a bad lead byte was seen, so the
//   string is to be dropped; after a bad lead the rest of the string gives no
//   beats until the terminator.
// throughput: one byte per clock while the result is not stalled, set by the
//   decode step in the back end; bytes that produce no result still pass it.
// path: an accepted byte is written into the queue, then decoded from the
//   queue head into the result register that drives its result beat.
// reset: rst_n low clears the queue, the sequence state, the count and the
//   result valid; the block accepts bytes as soon as rst_n is high again.
// stall: a stalled result holds; the back end stops popping while the queue
//   keeps absorbing up to four bytes, then in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decoder #(
  parameter int COUNT_BITS = 16  // width of the saturating char counter, 8..32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // byte input
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [u8sd_pkg::DATA_W-1:0]        in_data_byte,
  // decoded results
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [u8sd_pkg::CP_W-1:0]               out_code_point,
  output logic                                    out_char_valid,
  output logic                                    out_is_last,
  output logic [u8sd_pkg::CNT_OUT_W-1:0]          out_char_count,
  output logic                                    out_bad_lead
);

  // front to queue
  logic                 push;
  u8sd_pkg::q_entry_t   push_entry;
  // queue to back
  logic                 pop;
  u8sd_pkg::q_entry_t   head_entry;
  u8sd_pkg::q_status_t  q_status;

  // classify and mask each byte as it is accepted
  u8sd_front u_front (
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_stall     (in_stall),
    .q_status     (q_status),
    .push         (push),
    .push_entry   (push_entry)
  );

  // decouples input acceptance from result stalls
  u8sd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_entry (head_entry),
    .q_status   (q_status)
  );

  // sequence assembly, counting and the output register
  u8sd_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_entry     (head_entry),
    .q_status       (q_status),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point),
    .out_char_valid (out_char_valid),
    .out_is_last    (out_is_last),
    .out_char_count (out_char_count),
    .out_bad_lead   (out_bad_lead)
  );

endmodule

`default_nettype wire
